@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/ama_pkg.sv @@
// ---------------------------------------------------------------------------
// Affine matrix accumulator package
// Command codes, the multiplier chunk width and the fixed constants of the sine and cosine unit.
// ---------------------------------------------------------------------------
package ama_pkg;

    typedef enum logic [2:0] {
        MODE_RESET     = 3'd0,
        MODE_TRANSLATE = 3'd1,
        MODE_SCALE     = 3'd2,
        MODE_ROT_X     = 3'd3,
        MODE_ROT_Y     = 3'd4,
        MODE_ROT_Z     = 3'd5
    } ama_mode_t;

    localparam int CHUNK_BITS   = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_FRAC  = 30;

    localparam logic [31:0] CORDIC_GAIN = 32'h26DD_3B6A;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005
    };

endpackage

@@ sv/ama_if.sv @@
// ---------------------------------------------------------------------------
// Affine matrix accumulator channels
// Valid/ready channels for transform commands and for emitted matrix entries.
// ---------------------------------------------------------------------------
interface ama_cmd_if #(
    parameter int WORD_WIDTH = 32,
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   mode;
    logic signed [WORD_WIDTH-1:0] x_amount;
    logic signed [WORD_WIDTH-1:0] y_amount;
    logic signed [WORD_WIDTH-1:0] z_amount;
    logic [ANGLE_BITS-1:0]        angle;

    modport source (
        output valid, mode, x_amount, y_amount, z_amount, angle,
        input  ready
    );

    modport sink (
        input  valid, mode, x_amount, y_amount, z_amount, angle,
        output ready
    );
endinterface

interface ama_entry_if #(
    parameter int WORD_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   row_index;
    logic [1:0]                   col_index;
    logic signed [WORD_WIDTH-1:0] entry_value;
    logic                         last_entry;

    modport source (
        output valid, row_index, col_index, entry_value, last_entry,
        input  ready
    );

    modport sink (
        input  valid, row_index, col_index, entry_value, last_entry,
        output ready
    );
endinterface

@@ sv/affine_matrix_accumulator.sv @@
// ---------------------------------------------------------------------------
// Affine matrix accumulator
// Holds a 4x4 homogeneous transform in signed fixed point and premultiplies
// it in place by one translate, scale or rotate command at a time.
// ---------------------------------------------------------------------------
// Usage: a command word on cmd carries the mode, the x, y and z amounts and
// the angle. Every command, including a reset or an unused mode, answers
// with sixteen words on entry in column-major order, the last one flagged.
// One shared multiplier forms every product in (WORD_WIDTH+15)/16 passes,
// followed by an accumulate step; products with a zero transform entry are
// skipped. Each result passes through a select state, each column through a
// write-back state, and the sixteen words are then emitted one by one.
// A rotation first runs the sine and cosine iteration.
// cmd is ready only while no command is in progress; it becomes ready again
// as soon as the last word is loaded into the output register.
// A stalled receiver holds the output register and stops the sequencer.
// Reset sets the matrix to the identity and leaves both channels idle.
// ---------------------------------------------------------------------------
module affine_matrix_accumulator
    import ama_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    ama_cmd_if.sink      cmd,
    ama_entry_if.source  entry
);

    localparam int W         = WORD_WIDTH;
    localparam int TW        = W + 1;
    localparam int NCHUNK    = (W + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CW        = NCHUNK * CHUNK_BITS;
    localparam int PW        = TW + CW;
    localparam int AW        = PW + 2;
    localparam int CIW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int XYW       = 34;
    localparam int RND_SHIFT = CORDIC_FRAC - FRAC_BITS;
    localparam int RND_POS   = (RND_SHIFT > 0) ? RND_SHIFT - 1 : 0;

    localparam logic signed [AW-1:0]  SAT_HI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0]  SAT_LO = ~SAT_HI;
    localparam logic signed [TW-1:0]  UNITY  = (FRAC_BITS <= W - 2) ?
                                               (TW'(1) << FRAC_BITS) :
                                               {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   UNITY_W = UNITY[W-1:0];
    localparam logic signed [XYW-1:0] Q30_RND = (RND_SHIFT > 0) ?
                                                (XYW'(1) << RND_POS) : '0;
    localparam logic [CIW-1:0]        TOP_CHUNK = CIW'(NCHUNK - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_ROTFIX,
        S_SELECT,
        S_MUL,
        S_ACCUM,
        S_COMMIT,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [4:0]             step_reg;
    logic [1:0]             col_reg;
    logic [1:0]             row_reg;
    logic [1:0]             k_reg;
    logic [3:0]             rem_reg;
    logic [CIW-1:0]         chunk_reg;
    logic [3:0]             idx_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_row_reg;
    logic [1:0]             out_col_reg;
    logic signed [W-1:0]    out_value_reg;
    logic                   out_last_reg;

    logic [2:0]             mode_reg;
    logic signed [W-1:0]    x_reg;
    logic signed [W-1:0]    y_reg;
    logic signed [W-1:0]    z_reg;
    logic signed [W-1:0]    c_reg;
    logic signed [W-1:0]    s_reg;
    logic signed [XYW-1:0]  cx_reg;
    logic signed [XYW-1:0]  cy_reg;
    logic [31:0]            cz_reg;
    logic [1:0]             quad_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [W-1:0]    temp_reg [4];
    logic signed [W-1:0]    mat_reg  [16];

    logic                   in_acc;
    logic                   out_load;
    logic [31:0]            a_in;
    logic [1:0]             quad_in;
    logic [31:0]            z_in;
    logic signed [XYW-1:0]  dx;
    logic signed [XYW-1:0]  dy;
    logic signed [XYW-1:0]  rx;
    logic signed [XYW-1:0]  ry;
    logic signed [XYW-1:0]  cq30;
    logic signed [XYW-1:0]  sq30;
    logic signed [TW-1:0]   x_ext;
    logic signed [TW-1:0]   y_ext;
    logic signed [TW-1:0]   z_ext;
    logic signed [TW-1:0]   c_ext;
    logic signed [TW-1:0]   s_ext;
    logic signed [TW-1:0]   neg_s;
    logic signed [TW-1:0]   t_row [4];
    logic [3:0]             mask;
    logic signed [TW-1:0]   t_sel;
    logic [3:0]             rd_addr;
    logic signed [W-1:0]    rd_word;
    logic signed [CW-1:0]   b_ext;
    logic [CHUNK_BITS-1:0]  piece;
    logic signed [CHUNK_BITS:0] opnd;
    logic signed [TW+CHUNK_BITS:0] partial;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   shifted;
    logic signed [AW-1:0]   acc_next;
    logic signed [W-1:0]    sat_acc;
    logic [3:0]             rem_after;

    function automatic logic signed [W-1:0] sat_word(input logic signed [AW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[W-1:0];
        end
        else if (v < SAT_LO) begin
            r = SAT_LO[W-1:0];
        end
        else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] first_bit(input logic [3:0] m);
        logic [1:0] f;
        f = 2'd3;
        if (m[2]) begin
            f = 2'd2;
        end
        if (m[1]) begin
            f = 2'd1;
        end
        if (m[0]) begin
            f = 2'd0;
        end
        return f;
    endfunction

    assign in_acc   = cmd.valid && cmd.ready;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || entry.ready);

    assign cmd.ready         = (state_reg == S_IDLE);
    assign entry.valid       = out_valid_reg;
    assign entry.row_index   = out_row_reg;
    assign entry.col_index   = out_col_reg;
    assign entry.entry_value = out_value_reg;
    assign entry.last_entry  = out_last_reg;

    assign a_in    = {cmd.angle, {(32-ANGLE_BITS){1'b0}}};
    assign quad_in = 2'((a_in + 32'h2000_0000) >> 30);
    assign z_in    = a_in - {quad_in, 30'b0};

    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;

    always_comb
    begin
        case (quad_reg)
            2'd1:
            begin
                rx = -cy_reg;
                ry = cx_reg;
            end
            2'd2:
            begin
                rx = -cx_reg;
                ry = -cy_reg;
            end
            2'd3:
            begin
                rx = cy_reg;
                ry = -cx_reg;
            end
            default:
            begin
                rx = cx_reg;
                ry = cy_reg;
            end
        endcase
    end

    assign cq30 = (rx + Q30_RND) >>> RND_SHIFT;
    assign sq30 = (ry + Q30_RND) >>> RND_SHIFT;

    assign x_ext = TW'(x_reg);
    assign y_ext = TW'(y_reg);
    assign z_ext = TW'(z_reg);
    assign c_ext = TW'(c_reg);
    assign s_ext = TW'(s_reg);
    assign neg_s = -s_ext;

    // Row of the elementary transform for the entry being computed.
    always_comb
    begin
        for (int k = 0; k < 4; k++) begin
            t_row[k] = (2'(k) == row_reg) ? UNITY : '0;
        end
        case (mode_reg)
            MODE_TRANSLATE:
            begin
                if (row_reg == 2'd0) begin
                    t_row[3] = x_ext;
                end
                else if (row_reg == 2'd1) begin
                    t_row[3] = y_ext;
                end
                else if (row_reg == 2'd2) begin
                    t_row[3] = z_ext;
                end
            end
            MODE_SCALE:
            begin
                if (row_reg == 2'd0) begin
                    t_row[0] = x_ext;
                end
                else if (row_reg == 2'd1) begin
                    t_row[1] = y_ext;
                end
                else if (row_reg == 2'd2) begin
                    t_row[2] = z_ext;
                end
            end
            MODE_ROT_X:
            begin
                if (row_reg == 2'd1) begin
                    t_row[1] = c_ext;
                    t_row[2] = s_ext;
                end
                else if (row_reg == 2'd2) begin
                    t_row[1] = neg_s;
                    t_row[2] = c_ext;
                end
            end
            MODE_ROT_Y:
            begin
                if (row_reg == 2'd0) begin
                    t_row[0] = c_ext;
                    t_row[2] = neg_s;
                end
                else if (row_reg == 2'd2) begin
                    t_row[0] = s_ext;
                    t_row[2] = c_ext;
                end
            end
            MODE_ROT_Z:
            begin
                if (row_reg == 2'd0) begin
                    t_row[0] = c_ext;
                    t_row[1] = neg_s;
                end
                else if (row_reg == 2'd1) begin
                    t_row[0] = s_ext;
                    t_row[1] = c_ext;
                end
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            mask[k] = (t_row[k] != '0);
        end
    end

    assign t_sel   = t_row[k_reg];
    assign rd_addr = (state_reg == S_EMIT) ? idx_reg : {col_reg, k_reg};
    assign rd_word = mat_reg[rd_addr];
    assign b_ext   = CW'(rd_word);
    assign piece   = b_ext[chunk_reg*CHUNK_BITS +: CHUNK_BITS];
    assign opnd    = {(chunk_reg == TOP_CHUNK) & piece[CHUNK_BITS-1], piece};

    // Most significant chunk first, so that each pass shifts by a fixed amount.
    assign partial   = t_sel * opnd;
    assign prod_next = (prod_reg <<< CHUNK_BITS) + PW'(partial);
    assign shifted   = prod_reg >>> FRAC_BITS;
    assign acc_next  = acc_reg + AW'(shifted);
    assign sat_acc   = sat_word(acc_next);
    assign rem_after = rem_reg & ~(4'b0001 << k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            k_reg         <= '0;
            rem_reg       <= '0;
            chunk_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                out_row_reg   <= idx_reg[1:0];
                out_col_reg   <= idx_reg[3:2];
                out_value_reg <= rd_word;
                out_last_reg  <= (idx_reg == 4'hF);
            end
            else if (entry.ready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                    step_reg <= '0;
                    if (in_acc) begin
                        case (cmd.mode)
                            MODE_TRANSLATE, MODE_SCALE:
                            begin
                                state_reg <= S_SELECT;
                            end
                            MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z:
                            begin
                                state_reg <= S_CORDIC;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CORDIC:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_ROTFIX;
                    end
                end
                S_ROTFIX:
                begin
                    state_reg <= S_SELECT;
                end
                S_SELECT:
                begin
                    if (mask == 4'b0000) begin
                        if (row_reg == 2'd3) begin
                            state_reg <= S_COMMIT;
                        end
                        else begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                    else begin
                        k_reg     <= first_bit(mask);
                        rem_reg   <= mask;
                        chunk_reg <= TOP_CHUNK;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (chunk_reg == '0) begin
                        state_reg <= S_ACCUM;
                    end
                    else begin
                        chunk_reg <= chunk_reg - CIW'(1);
                    end
                end
                S_ACCUM:
                begin
                    if (rem_after == 4'b0000) begin
                        if (row_reg == 2'd3) begin
                            state_reg <= S_COMMIT;
                        end
                        else begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= S_SELECT;
                        end
                    end
                    else begin
                        k_reg     <= first_bit(rem_after);
                        rem_reg   <= rem_after;
                        chunk_reg <= TOP_CHUNK;
                        state_reg <= S_MUL;
                    end
                end
                S_COMMIT:
                begin
                    row_reg <= '0;
                    if (col_reg == 2'd3) begin
                        state_reg <= S_EMIT;
                    end
                    else begin
                        col_reg   <= col_reg + 2'd1;
                        state_reg <= S_SELECT;
                    end
                end
                S_EMIT:
                begin
                    if (out_load) begin
                        idx_reg <= idx_reg + 4'd1;
                        if (idx_reg == 4'hF) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            mode_reg <= cmd.mode;
            x_reg    <= cmd.x_amount;
            y_reg    <= cmd.y_amount;
            z_reg    <= cmd.z_amount;
            quad_reg <= quad_in;
            cx_reg   <= XYW'(CORDIC_GAIN);
            cy_reg   <= '0;
            cz_reg   <= z_in;
        end
        case (state_reg)
            S_CORDIC:
            begin
                if (!cz_reg[31]) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - ATAN_TURNS[step_reg];
                end
                else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + ATAN_TURNS[step_reg];
                end
            end
            S_ROTFIX:
            begin
                c_reg <= sat_word(AW'(cq30));
                s_reg <= sat_word(AW'(sq30));
            end
            S_SELECT:
            begin
                prod_reg <= '0;
                acc_reg  <= '0;
                if (mask == 4'b0000) begin
                    temp_reg[row_reg] <= '0;
                end
            end
            S_MUL:
            begin
                prod_reg <= prod_next;
            end
            S_ACCUM:
            begin
                prod_reg <= '0;
                acc_reg  <= acc_next;
                if (rem_after == 4'b0000) begin
                    temp_reg[row_reg] <= sat_acc;
                end
            end
            default:
            begin
            end
        endcase
    end

    // A new column depends only on the old column, so it is written back whole.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= (i % 4 == i / 4) ? UNITY_W : '0;
            end
        end
        else if (in_acc && (cmd.mode == MODE_RESET)) begin
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= (i % 4 == i / 4) ? UNITY_W : '0;
            end
        end
        else if (state_reg == S_COMMIT) begin
            for (int r = 0; r < 4; r++) begin
                mat_reg[{col_reg, 2'(r)}] <= temp_reg[r];
            end
        end
    end

endmodule

@@ sv/ama_checker.sv @@
// ---------------------------------------------------------------------------
// Affine matrix accumulator checker
// Port-level checks on command acceptance and the emitted entry sequence.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ama_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       entry_valid,
    input logic       entry_ready,
    input logic [1:0] row_index,
    input logic [1:0] col_index,
    input logic       last_entry
);

    `AMA_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)
    `AMA_ASSERT_NOW(a_busy_mid_run, clk, rst_n, entry_valid && entry_ready && !last_entry, !cmd_ready)
    `AMA_ASSERT_NOW(a_last_on_final, clk, rst_n, entry_valid, last_entry == (row_index == 2'd3 && col_index == 2'd3))
    `AMA_ASSERT_NEXT(a_stalled_word_holds, clk, rst_n, entry_valid && !entry_ready, entry_valid && $stable(row_index) && $stable(col_index))

endmodule

bind affine_matrix_accumulator ama_checker u_ama_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .entry_valid (entry.valid),
    .entry_ready (entry.ready),
    .row_index   (entry.row_index),
    .col_index   (entry.col_index),
    .last_entry  (entry.last_entry)
);

@@ tb/tb_affine_matrix_accumulator.sv @@
// ---------------------------------------------------------------------------
// Affine matrix accumulator testbench
// Sends transform commands and checks every emitted matrix word against a
// fixed-point model of the accumulated 4x4 transform kept in the testbench.
// The run starts with directed commands: reset, the unused modes, extreme
// amounts, saturating products and rotations on the quadrant boundaries.
// Random command sequences follow. The sender works in bursts, and the
// receiver stalls in patterns of its own.
// ---------------------------------------------------------------------------
module tb_affine_matrix_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    import ama_pkg::*;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        word_t      value;
        logic       last;
    } matrix_word_t;

    localparam int    FRAC       = 16;
    localparam word_t UNITY      = 32'sh0001_0000;
    localparam word_t WORD_MAX   = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN   = 32'sh8000_0000;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam longint GAIN_Q30  = 64'sh0000_0000_26DD_3B6A;
    localparam logic [31:0] ARCTAN_STEP [28] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005
    };

    logic clk = 1'b0;
    logic rst_n;

    ama_cmd_if   cmd_ch ();
    ama_entry_if word_ch ();

    affine_matrix_accumulator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .entry (word_ch)
    );

    always #10 clk = ~clk;

    word_t        matrix_state [16];
    matrix_word_t pending_words [$];
    int           error_count = 0;
    int           burst_left  = 0;
    int           stall_style = 0;
    int           stall_left  = 0;

    function automatic word_t identity_entry(input int k);
        return ((k % 4) == (k / 4)) ? UNITY : 32'sd0;
    endfunction

    function automatic word_t saturate_word(input longint v);
        if (v > 64'sd2147483647)
            return WORD_MAX;
        if (v < -64'sd2147483648)
            return WORD_MIN;
        return v[31:0];
    endfunction

    function automatic void sine_cosine(input logic [15:0] ang, output word_t cos_w,
                                        output word_t sin_w);
        logic [31:0] a;
        logic [31:0] z;
        logic [31:0] shifted;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      swap;
        a       = {ang, 16'h0000};
        shifted = a + 32'h2000_0000;
        quad    = shifted[31:30];
        z       = a - {quad, 30'd0};
        x       = GAIN_Q30;
        y       = 0;
        for (int i = 0; i < 28; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (!z[31])
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
        end
        case (quad)
            2'd1:
            begin
                swap = x;
                x    = -y;
                y    = swap;
            end
            2'd2:
            begin
                x = -x;
                y = -y;
            end
            2'd3:
            begin
                swap = x;
                x    = y;
                y    = -swap;
            end
            default:
            begin
            end
        endcase
        cos_w = saturate_word((x + 64'sd8192) >>> 14);
        sin_w = saturate_word((y + 64'sd8192) >>> 14);
    endfunction

    // Premultiplies the held matrix by the commanded transform (a reset restores
    // the identity), then queues the sixteen words that the block must emit.
    function automatic void apply_transform(input logic [2:0] m, input word_t xa,
                                            input word_t ya, input word_t za,
                                            input logic [15:0] ang);
        longint t [16];
        word_t  updated [16];
        word_t  c;
        word_t  s;
        longint acc;
        bit     apply;
        apply = 1'b1;
        for (int k = 0; k < 16; k++)
            t[k] = identity_entry(k);
        case (m)
            MODE_RESET:
            begin
                for (int k = 0; k < 16; k++)
                    matrix_state[k] = identity_entry(k);
                apply = 1'b0;
            end
            MODE_TRANSLATE:
            begin
                t[12] = xa;
                t[13] = ya;
                t[14] = za;
            end
            MODE_SCALE:
            begin
                t[0]  = xa;
                t[5]  = ya;
                t[10] = za;
            end
            MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z:
            begin
                sine_cosine(ang, c, s);
                if (m == MODE_ROT_X)
                begin
                    t[5]  = c;
                    t[9]  = s;
                    t[6]  = -longint'(s);
                    t[10] = c;
                end
                else if (m == MODE_ROT_Y)
                begin
                    t[0]  = c;
                    t[8]  = -longint'(s);
                    t[2]  = s;
                    t[10] = c;
                end
                else
                begin
                    t[0] = c;
                    t[4] = -longint'(s);
                    t[1] = s;
                    t[5] = c;
                end
            end
            default:
                apply = 1'b0;
        endcase
        if (apply)
        begin
            for (int col = 0; col < 4; col++)
                for (int r = 0; r < 4; r++)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc = acc + ((t[k * 4 + r] * longint'(matrix_state[col * 4 + k]))
                                     >>> FRAC);
                    updated[col * 4 + r] = saturate_word(acc);
                end
            matrix_state = updated;
        end
        for (int k = 0; k < 16; k++)
            pending_words.push_back('{row: k[1:0], col: k[3:2], value: matrix_state[k],
                                      last: (k == 15)});
    endfunction

    task automatic send_command(input logic [2:0] m, input word_t xa, input word_t ya,
                                input word_t za, input logic [15:0] ang);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 160) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= m;
        cmd_ch.x_amount <= xa;
        cmd_ch.y_amount <= ya;
        cmd_ch.z_amount <= za;
        cmd_ch.angle    <= ang;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        apply_transform(m, xa, ya, za, ang);
    endtask

    task automatic wait_for_all_words();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t pick_amount(input bit for_scale);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            case ($urandom_range(0, 4))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return UNITY;
            endcase
        end
        if (sel < 25)
            return $urandom;
        if (for_scale)
            return word_t'($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
        return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    function automatic logic [15:0] pick_angle();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom_range(0, 7) << 13);
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic test_reset_and_unused_modes();
        send_command(MODE_RESET, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
        send_command(MODE_SPARE_A, WORD_MAX, WORD_MIN, -32'sd1, 16'hFFFF);
        send_command(MODE_SCALE, 32'sh0002_0000, 32'sh0003_0000, 32'sh0000_8000, 16'h0000);
        send_command(MODE_SPARE_B, WORD_MIN, WORD_MAX, 32'sd0, 16'h5555);
        send_command(MODE_RESET, WORD_MAX, WORD_MAX, WORD_MAX, 16'hFFFF);
    endtask

    task automatic test_translate();
        send_command(MODE_TRANSLATE, 32'sh0001_8000, -32'sh0002_0000, WORD_MAX, 16'h0000);
        send_command(MODE_TRANSLATE, WORD_MIN, -32'sd1, 32'sd1, 16'hAAAA);
        send_command(MODE_TRANSLATE, WORD_MAX, WORD_MAX, WORD_MIN, 16'h0000);
        wait_for_all_words();
    endtask

    task automatic test_scale();
        send_command(MODE_RESET, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
        send_command(MODE_SCALE, 32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000, 16'h0000);
        send_command(MODE_SCALE, 32'sd0, -32'sd1, 32'sd1, 16'h0000);
    endtask

    task automatic test_rotation();
        send_command(MODE_RESET, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
        send_command(MODE_TRANSLATE, 32'sh0003_0000, 32'sh0005_0000, -32'sh0007_0000, 16'h0);
        send_command(MODE_ROT_X, 32'sd0, 32'sd0, 32'sd0, 16'h4000);
        send_command(MODE_ROT_Y, 32'sd0, 32'sd0, 32'sd0, 16'h2000);
        send_command(MODE_ROT_Z, 32'sd0, 32'sd0, 32'sd0, 16'h8000);
        send_command(MODE_ROT_Z, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF);
        send_command(MODE_ROT_X, 32'sd0, 32'sd0, 32'sd0, 16'hE000);
        send_command(MODE_ROT_Y, 32'sd0, 32'sd0, 32'sd0, 16'hA000);
    endtask

    task automatic test_saturation();
        send_command(MODE_SCALE, WORD_MAX, WORD_MAX, WORD_MAX, 16'h0000);
        send_command(MODE_SCALE, WORD_MIN, WORD_MIN, WORD_MIN, 16'h0000);
        send_command(MODE_ROT_Z, 32'sd0, 32'sd0, 32'sd0, 16'h6000);
        send_command(MODE_TRANSLATE, WORD_MIN, WORD_MAX, WORD_MIN, 16'h0000);
    endtask

    // Mostly well-formed chains of transforms on the held matrix, with the odd
    // reset, unused mode and extreme amount mixed in.
    task automatic test_random_sequences(input int count);
        int          sel;
        logic [2:0]  m;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                m = MODE_RESET;
            else if (sel < 8)
                m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
            else if (sel < 30)
                m = MODE_TRANSLATE;
            else if (sel < 55)
                m = MODE_SCALE;
            else if (sel < 70)
                m = MODE_ROT_X;
            else if (sel < 85)
                m = MODE_ROT_Y;
            else
                m = MODE_ROT_Z;
            send_command(m, pick_amount(m == MODE_SCALE), pick_amount(m == MODE_SCALE),
                         pick_amount(m == MODE_SCALE), pick_angle());
            if (n == count / 2)
                wait_for_all_words();
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 400);
        end
        stall_left = stall_left - 1;
        case (stall_style)
            0: word_ch.ready <= 1'b1;
            1: word_ch.ready <= ($urandom_range(0, 3) != 0);
            2: word_ch.ready <= ($urandom_range(0, 1) == 0);
            default: word_ch.ready <= ((stall_left % 7) < 2);
        endcase
    end

    always @(posedge clk)
    begin
        matrix_word_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word row %0d col %0d value %h last %b", $time,
                         word_ch.row_index, word_ch.col_index, word_ch.entry_value,
                         word_ch.last_entry);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_words.pop_front();
                if (word_ch.row_index !== want.row || word_ch.col_index !== want.col ||
                    word_ch.entry_value !== want.value || word_ch.last_entry !== want.last)
                begin
                    $display("%0t: expected row %0d col %0d value %h last %b, got row %0d col %0d value %h last %b",
                             $time, want.row, want.col, want.value, want.last,
                             word_ch.row_index, word_ch.col_index, word_ch.entry_value,
                             word_ch.last_entry);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_RESET;
        cmd_ch.x_amount = '0;
        cmd_ch.y_amount = '0;
        cmd_ch.z_amount = '0;
        cmd_ch.angle    = '0;
        word_ch.ready   = 1'b0;
        for (int k = 0; k < 16; k++)
            matrix_state[k] = identity_entry(k);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_and_unused_modes();
        test_translate();
        test_scale();
        test_rotation();
        test_saturation();
        test_random_sequences(450);
        wait_for_all_words();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
